// ----- rtl/core/sdspi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared constants, phase codes and command frame tables for the SD SPI
// initialization engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int CLOCKING_BYTES_DEF = 10;
    localparam int CLK_CNT_W = 7;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_CLOCK = 4'd1;
    localparam logic [3:0] PH_DONE  = 4'd2;
    localparam logic [3:0] PH_CMD0  = 4'd3;
    localparam logic [3:0] PH_CMD8  = 4'd4;
    localparam logic [3:0] PH_V2_55 = 4'd5;
    localparam logic [3:0] PH_V2_41 = 4'd6;
    localparam logic [3:0] PH_CMD58 = 4'd7;
    localparam logic [3:0] PH_P_55  = 4'd8;
    localparam logic [3:0] PH_P_41  = 4'd9;
    localparam logic [3:0] PH_V1_55 = 4'd10;
    localparam logic [3:0] PH_V1_41 = 4'd11;
    localparam logic [3:0] PH_MMC_1 = 4'd12;
    localparam logic [3:0] PH_CMD16 = 4'd13;

    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_FRAME = 2'd1;
    localparam logic [1:0] ST_RESP  = 2'd2;
    localparam logic [1:0] ST_TRAIL = 2'd3;

    localparam logic [1:0] REG_READY_LIM = 2'd0;
    localparam logic [1:0] REG_RESP_LIM  = 2'd1;
    localparam logic [1:0] REG_IDLE_RET  = 2'd2;
    localparam logic [1:0] REG_OPC_RET   = 2'd3;

    localparam logic [2:0] CARD_NONE  = 3'd0;
    localparam logic [2:0] CARD_MMC   = 3'd1;
    localparam logic [2:0] CARD_SD1   = 3'd2;
    localparam logic [2:0] CARD_SD2   = 3'd3;
    localparam logic [2:0] CARD_SD2HC = 3'd4;

    function automatic logic [7:0] frame_byte(input logic [3:0] ph, input logic [2:0] idx);
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  crc;
        cmd = 6'd0;
        arg = 32'd0;
        crc = 8'h01;
        case (ph)
            PH_CMD0: begin
                cmd = 6'd0;
                crc = 8'h95;
            end
            PH_CMD8: begin
                cmd = 6'd8;
                arg = 32'h0000_01AA;
                crc = 8'h87;
            end
            PH_V2_55, PH_P_55, PH_V1_55: cmd = 6'd55;
            PH_V2_41: begin
                cmd = 6'd41;
                arg = 32'h4000_0000;
            end
            PH_P_41, PH_V1_41: cmd = 6'd41;
            PH_CMD58: cmd = 6'd58;
            PH_MMC_1: cmd = 6'd1;
            PH_CMD16: begin
                cmd = 6'd16;
                arg = 32'd512;
            end
            default: cmd = 6'd0;
        endcase
        case (idx)
            3'd0: frame_byte = {2'b01, cmd};
            3'd1: frame_byte = arg[31:24];
            3'd2: frame_byte = arg[23:16];
            3'd3: frame_byte = arg[15:8];
            3'd4: frame_byte = arg[7:0];
            default: frame_byte = crc;
        endcase
    endfunction

endpackage

// ----- rtl/core/sdspi_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_cfg
// APB register file holding the poll and retry limits.
// ----------------------------------------------------------------------------
module sdspi_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [19:0] o_ready_lim,
    output logic [7:0]  o_resp_lim,
    output logic [7:0]  o_idle_ret,
    output logic [15:0] o_opc_ret
);
    import sdspi_pkg::*;

    logic [19:0] r_ready_lim;
    logic [7:0]  r_resp_lim;
    logic [7:0]  r_idle_ret;
    logic [15:0] r_opc_ret;
    logic        wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_lim <= 20'hFFFFF;
            r_resp_lim  <= 8'd32;
            r_idle_ret  <= 8'd20;
            r_opc_ret   <= 16'hFFFE;
        end else if (wr) begin
            case (paddr[3:2])
                REG_READY_LIM: r_ready_lim <= pwdata[19:0];
                REG_RESP_LIM:  r_resp_lim  <= pwdata[7:0];
                REG_IDLE_RET:  r_idle_ret  <= pwdata[7:0];
                REG_OPC_RET:   r_opc_ret   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_READY_LIM: prdata = {12'd0, r_ready_lim};
            REG_RESP_LIM:  prdata = {24'd0, r_resp_lim};
            REG_IDLE_RET:  prdata = {24'd0, r_idle_ret};
            REG_OPC_RET:   prdata = {16'd0, r_opc_ret};
            default:       prdata = 32'd0;
        endcase
    end

    assign o_ready_lim = r_ready_lim;
    assign o_resp_lim  = r_resp_lim;
    assign o_idle_ret  = r_idle_ret;
    assign o_opc_ret   = r_opc_ret;
endmodule

// ----- rtl/core/sd_spi_card_init_identify.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_card_init_identify
// SD card SPI-mode initialization and identification engine.
//
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_kind, i_rx_byte
//   output  | out       | o_valid / i_stall  | o_tx_byte .. o_result_code
//   config  | in        | APB                | four limit registers
//
// For each beat, the state step and result are computed from the
// current state and registered into the output stage in the same edge.
// A new beat is taken every cycle unless the output stage is full and stalled.
// Reset is synchronous; the engine starts idle with reset limits.
// ----------------------------------------------------------------------------
module sd_spi_card_init_identify #(
    parameter int CLOCKING_BYTES = sdspi_pkg::CLOCKING_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_valid,
    output logic        o_select_low,
    output logic        o_fast_clock,
    output logic        o_done_res,
    output logic [2:0]  o_card_kind,
    output logic [7:0]  o_result_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sdspi_pkg::*;

    logic [19:0] ready_lim;
    logic [7:0]  resp_lim;
    logic [7:0]  idle_ret;
    logic [15:0] opc_ret;

    sdspi_cfg u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_ready_lim(ready_lim), .o_resp_lim(resp_lim),
        .o_idle_ret(idle_ret), .o_opc_ret(opc_ret)
    );

    logic [3:0]  r_phase, n_phase;
    logic [1:0]  r_stage, n_stage;
    logic [2:0]  r_fidx, n_fidx;
    logic [19:0] r_poll, n_poll;
    logic [15:0] r_retry, n_retry;
    logic [7:0]  r_last, n_last;
    logic [2:0]  r_ctype, n_ctype;
    logic [7:0]  r_trail [4];
    logic [7:0]  r_trail0, n_trail0;

    logic        r_ovalid;
    logic [7:0]  r_tx;
    logic        r_txv, r_sel, r_fast, r_done;
    logic [2:0]  r_kind;
    logic [7:0]  r_code;

    logic        acc;
    logic        r1_go;
    logic [7:0]  r1_val;
    logic        twr;
    logic [7:0]  tx_n;
    logic [19:0] poll_inc;

    assign o_stall = r_ovalid && i_stall;
    assign acc = i_valid && !o_stall;
    assign poll_inc = r_poll + 20'd1;

    always_comb begin
        n_phase = r_phase;
        n_stage = r_stage;
        n_fidx = r_fidx;
        n_poll = r_poll;
        n_retry = r_retry;
        n_last = r_last;
        n_ctype = r_ctype;
        n_trail0 = r_trail0;
        r1_go = 1'b0;
        r1_val = 8'hFF;
        twr = 1'b0;
        if (!i_kind) begin
            n_phase = PH_CLOCK;
            n_poll = 20'd1;
            n_ctype = CARD_NONE;
            n_last = 8'hFF;
        end else if (r_phase == PH_CLOCK) begin
            if (r_poll < 20'(CLOCKING_BYTES)) begin
                n_poll = poll_inc;
            end else begin
                n_retry = {8'd0, idle_ret};
                n_phase = PH_CMD0;
                n_stage = ST_READY;
                n_poll = 20'd0;
            end
        end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
            case (r_stage)
                ST_READY: begin
                    if (i_rx_byte == 8'hFF) begin
                        n_stage = ST_FRAME;
                        n_fidx = 3'd0;
                    end else begin
                        n_poll = poll_inc;
                        if (poll_inc >= ready_lim) begin
                            r1_go = 1'b1;
                            r1_val = 8'hFF;
                        end
                    end
                end
                ST_FRAME: begin
                    if (r_fidx < 3'd5) begin
                        n_fidx = r_fidx + 3'd1;
                    end else begin
                        n_stage = ST_RESP;
                        n_poll = 20'd0;
                    end
                end
                ST_RESP: begin
                    n_poll = poll_inc;
                    if (!i_rx_byte[7] || poll_inc >= {12'd0, resp_lim}) begin
                        r1_go = 1'b1;
                        r1_val = i_rx_byte;
                    end
                end
                default: begin
                    twr = 1'b1;
                    if (r_fidx[1:0] == 2'd0) n_trail0 = i_rx_byte;
                    if (r_fidx < 3'd3) begin
                        n_fidx = r_fidx + 3'd1;
                    end else if (r_phase == PH_CMD8) begin
                        if (r_trail[2] == 8'h01 && i_rx_byte == 8'hAA) begin
                            n_retry = opc_ret;
                            n_phase = PH_V2_55;
                            n_stage = ST_READY;
                            n_poll = 20'd0;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end else begin
                        n_ctype = r_trail0[6] ? CARD_SD2HC : CARD_SD2;
                        n_phase = PH_DONE;
                    end
                end
            endcase
        end

        if (r1_go) begin
            n_stage = ST_READY;
            n_poll = 20'd0;
            case (r_phase)
                PH_CMD0: begin
                    n_last = r1_val;
                    if (r1_val == 8'h01) n_phase = PH_CMD8;
                    else if (r_retry == 16'd0) n_phase = PH_DONE;
                    else n_retry = r_retry - 16'd1;
                end
                PH_CMD8: begin
                    if (r1_val == 8'h01) begin
                        n_stage = ST_TRAIL;
                        n_fidx = 3'd0;
                    end else begin
                        n_phase = PH_P_55;
                    end
                end
                PH_V2_55: n_phase = PH_V2_41;
                PH_V2_41: begin
                    n_last = r1_val;
                    if (r1_val == 8'h00) n_phase = PH_CMD58;
                    else if (r_retry == 16'd0) n_phase = PH_DONE;
                    else begin
                        n_retry = r_retry - 16'd1;
                        n_phase = PH_V2_55;
                    end
                end
                PH_CMD58: begin
                    if (r1_val == 8'h00) begin
                        n_stage = ST_TRAIL;
                        n_fidx = 3'd0;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_P_55: n_phase = PH_P_41;
                PH_P_41: begin
                    n_last = r1_val;
                    n_retry = opc_ret;
                    if (r1_val <= 8'h01) begin
                        n_ctype = CARD_SD1;
                        n_phase = PH_V1_55;
                    end else begin
                        n_ctype = CARD_MMC;
                        n_phase = PH_MMC_1;
                    end
                end
                PH_V1_55: n_phase = PH_V1_41;
                PH_V1_41, PH_MMC_1: begin
                    n_last = r1_val;
                    if (r1_val == 8'h00) n_phase = PH_CMD16;
                    else if (r_retry == 16'd0) begin
                        n_ctype = CARD_NONE;
                        n_phase = PH_DONE;
                    end else begin
                        n_retry = r_retry - 16'd1;
                        n_phase = (r_phase == PH_V1_41) ? PH_V1_55 : PH_MMC_1;
                    end
                end
                default: begin
                    if (r1_val != 8'h00) n_ctype = CARD_NONE;
                    n_phase = PH_DONE;
                end
            endcase
        end

        tx_n = (n_phase != PH_CLOCK && n_stage == ST_FRAME) ?
               frame_byte(n_phase, n_fidx) : 8'hFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_stage <= ST_READY;
            r_fidx <= 3'd0;
            r_poll <= 20'd0;
            r_retry <= 16'd0;
            r_last <= 8'hFF;
            r_ctype <= CARD_NONE;
            r_ovalid <= 1'b0;
        end else begin
            if (acc) begin
                r_phase <= n_phase;
                r_stage <= n_stage;
                r_fidx <= n_fidx;
                r_poll <= n_poll;
                r_retry <= n_retry;
                r_last <= n_last;
                r_ctype <= n_ctype;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_trail0 <= n_trail0;
            if (twr) r_trail[r_fidx[1:0]] <= i_rx_byte;
            r_tx <= 8'h00;
            r_txv <= 1'b0;
            r_sel <= 1'b0;
            r_fast <= 1'b0;
            r_done <= 1'b0;
            r_kind <= CARD_NONE;
            r_code <= 8'h00;
            if (n_phase == PH_DONE) begin
                r_sel <= 1'b1;
                r_fast <= 1'b1;
                r_done <= 1'b1;
                r_kind <= n_ctype;
                r_code <= (n_ctype != CARD_NONE) ? 8'h00 :
                          ((n_last != 8'h00) ? n_last : 8'hFF);
            end else if (n_phase != PH_IDLE) begin
                r_tx <= tx_n;
                r_txv <= 1'b1;
                r_sel <= (n_phase != PH_CLOCK);
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_tx_byte = r_tx;
    assign o_tx_valid = r_txv;
    assign o_select_low = r_sel;
    assign o_fast_clock = r_fast;
    assign o_done_res = r_done;
    assign o_card_kind = r_kind;
    assign o_result_code = r_code;

`ifndef ASSERT_OFF
    a_done_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> o_fast_clock && o_select_low && !o_tx_valid)
        else $error("done beat without fast clock and select");
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_card_kind != CARD_NONE |-> o_result_code == 8'h00)
        else $error("card kind with nonzero result code");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_phase))
        else $error("state changed while stalled");
    a_fidx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fidx <= 3'd5)
        else $error("frame index out of range");
`endif
endmodule
